// ===== rtl/srr_pkg.sv =====
// Shared types and constants for the segment reorder receiver.
package srr_pkg;

   localparam int SEQ_W  = 31;
   localparam int SIZE_W = 11;
   localparam int TAG_W  = 8;

   localparam int DEF_REORDER_DEPTH = 16;
   localparam int DEF_MAX_PAYLOAD   = 1456;

   typedef enum logic [1:0] {
      KIND_DELIVER = 2'd0,
      KIND_ACK     = 2'd1,
      KIND_END     = 2'd2
   } kind_type;

   typedef struct packed {
      logic [SEQ_W-1:0]  seq_number;
      logic [SIZE_W-1:0] payload_size;
      logic [TAG_W-1:0]  payload_tag;
   } req_type;

   typedef struct packed {
      kind_type          kind;
      logic [SEQ_W-1:0]  position;
      logic [SIZE_W-1:0] out_size;
      logic [TAG_W-1:0]  out_tag;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [SEQ_W-1:0]  seq;
      logic [SIZE_W-1:0] size;
      logic [TAG_W-1:0]  tag;
   } slot_type;

   typedef struct packed {
      logic clr_all;
      logic clr_one;
      logic set_one;
   } slot_ctl_type;

endpackage

// ===== rtl/segment_reorder_receiver_unit.sv =====
// Segment reorder receiver: sequencer, expected offset and result register.
// An oversized item is dropped; an old item is answered with an ack and an end item with
// an end result; a future item is stored after a pass over the store (one slot a cycle).
// An expected item is delivered and then drains the stored segments that continue the stream:
// each delivery costs an output state, a store pass and a decision state.
// Held results stall the sequencer; synchronous reset empties the store and clears the offset.
module segment_reorder_receiver_unit
   import srr_pkg::*;
#(
   parameter int REORDER_DEPTH = DEF_REORDER_DEPTH,
   parameter int MAX_PAYLOAD   = DEF_MAX_PAYLOAD
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int IDX_W = $clog2(REORDER_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(REORDER_DEPTH - 1);
   localparam logic [IDX_W-1:0] DRAIN_MAX = IDX_W'(REORDER_DEPTH - 1);
   localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_PAYLOAD);

   typedef enum logic [6:0] {
      ST_IDLE       = 7'b0000001,
      ST_CLASS      = 7'b0000010,
      ST_INS_SCAN   = 7'b0000100,
      ST_INS_WRITE  = 7'b0001000,
      ST_OUT        = 7'b0010000,
      ST_DRAIN_SCAN = 7'b0100000,
      ST_DRAIN_DEC  = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   req_type            item_ff, item_in;
   logic [SEQ_W-1:0]   exp_ff, exp_in;
   rsp_type            res_ff, res_in;
   logic [IDX_W-1:0]   drained_ff, drained_in;
   logic               scan_run_ff, scan_run_in;
   logic [IDX_W-1:0]   scan_addr_ff, scan_addr_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               dup_ff, dup_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic               hit_found_ff, hit_found_in;
   logic [SIZE_W-1:0]  hit_size_ff, hit_size_in;
   logic [TAG_W-1:0]   hit_tag_ff, hit_tag_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   slot_ctl_type             slot_ctl;
   logic [IDX_W-1:0]         slot_idx;
   slot_type                 slot_wr;
   slot_type                 slot_rd;
   logic [REORDER_DEPTH-1:0] slot_valid;
   logic [SEQ_W-1:0]         cmp_a, cmp_b;
   logic                     cmp_eq, cmp_lt;
   logic                     cur_valid;
   logic                     scan_end;

   srr_slot_store #(
      .REORDER_DEPTH(REORDER_DEPTH)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .ctl        (slot_ctl),
      .idx        (slot_idx),
      .wr_data    (slot_wr),
      .rd_addr    (scan_addr_ff),
      .rd_data    (slot_rd),
      .slot_valid (slot_valid)
   );

   srr_cmp_unit u_cmp (
      .a  (cmp_a),
      .b  (cmp_b),
      .eq (cmp_eq),
      .lt (cmp_lt)
   );

   // The comparator classifies the item first, then checks one slot a cycle.
   assign cmp_a = (state_ff == ST_CLASS) ? item_ff.seq_number : slot_rd.seq;
   assign cmp_b = (state_ff == ST_INS_SCAN) ? item_ff.seq_number : exp_ff;

   assign cur_valid = cmp_vld_ff && slot_valid[cmp_idx_ff];
   assign scan_end  = cmp_vld_ff && (cmp_idx_ff == LAST_IDX);

   assign slot_wr.seq  = item_ff.seq_number;
   assign slot_wr.size = item_ff.payload_size;
   assign slot_wr.tag  = item_ff.payload_tag;

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      exp_in        = exp_ff;
      res_in        = res_ff;
      drained_in    = drained_ff;
      scan_run_in   = scan_run_ff;
      scan_addr_in  = scan_addr_ff;
      cmp_vld_in    = scan_run_ff;
      cmp_idx_in    = scan_addr_ff;
      dup_in        = dup_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      hit_found_in  = hit_found_ff;
      hit_size_in   = hit_size_ff;
      hit_tag_in    = hit_tag_ff;
      hit_idx_in    = hit_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      slot_ctl      = '0;
      slot_idx      = cmp_idx_ff;

      // advance the read address while a pass is running
      if (scan_run_ff) begin
         if (scan_addr_ff == LAST_IDX) begin
            scan_run_in  = 1'b0;
            scan_addr_in = '0;
         end else begin
            scan_addr_in = scan_addr_ff + 1'b1;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_CLASS;
            end
         end
         ST_CLASS: begin
            if (item_ff.payload_size == '0) begin
               slot_ctl.clr_all = 1'b1;
               res_in = '{kind: KIND_END, position: exp_ff, out_size: '0,
                          out_tag: '0, last: 1'b1};
               state_in = ST_OUT;
            end else if (item_ff.payload_size > MAX_SIZE) begin
               state_in = ST_IDLE;
            end else if (cmp_lt) begin
               res_in = '{kind: KIND_ACK, position: exp_ff, out_size: '0,
                          out_tag: '0, last: 1'b1};
               state_in = ST_OUT;
            end else if (!cmp_eq) begin
               scan_run_in   = 1'b1;
               scan_addr_in  = '0;
               dup_in        = 1'b0;
               free_found_in = 1'b0;
               state_in      = ST_INS_SCAN;
            end else begin
               res_in = '{kind: KIND_DELIVER, position: item_ff.seq_number,
                          out_size: item_ff.payload_size,
                          out_tag: item_ff.payload_tag, last: 1'b0};
               exp_in     = item_ff.seq_number + SEQ_W'(item_ff.payload_size);
               drained_in = '0;
               state_in   = ST_OUT;
            end
         end
         ST_INS_SCAN: begin
            if (cur_valid && cmp_eq) begin
               dup_in = 1'b1;
            end
            if (cmp_vld_ff && !slot_valid[cmp_idx_ff] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = cmp_idx_ff;
            end
            if (scan_end) begin
               state_in = ST_INS_WRITE;
            end
         end
         ST_INS_WRITE: begin
            // drop duplicates and items that find the store full
            if (!dup_ff && free_found_ff) begin
               slot_ctl.set_one = 1'b1;
               slot_idx         = free_idx_ff;
            end
            state_in = ST_IDLE;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               if (res_ff.last) begin
                  state_in = ST_IDLE;
               end else begin
                  scan_run_in  = 1'b1;
                  scan_addr_in = '0;
                  hit_found_in = 1'b0;
                  state_in     = ST_DRAIN_SCAN;
               end
            end
         end
         ST_DRAIN_SCAN: begin
            // purge stale slots and find the lowest slot that continues the stream
            if (cur_valid && cmp_lt) begin
               slot_ctl.clr_one = 1'b1;
            end else if (cur_valid && cmp_eq && !hit_found_ff) begin
               hit_found_in = 1'b1;
               hit_idx_in   = cmp_idx_ff;
               hit_size_in  = slot_rd.size;
               hit_tag_in   = slot_rd.tag;
            end
            if (scan_end) begin
               state_in = ST_DRAIN_DEC;
            end
         end
         ST_DRAIN_DEC: begin
            if (hit_found_ff && (drained_ff < DRAIN_MAX)) begin
               slot_ctl.clr_one = 1'b1;
               slot_idx         = hit_idx_ff;
               res_in = '{kind: KIND_DELIVER, position: exp_ff,
                          out_size: hit_size_ff, out_tag: hit_tag_ff,
                          last: 1'b0};
               exp_in     = exp_ff + SEQ_W'(hit_size_ff);
               drained_in = drained_ff + 1'b1;
            end else begin
               res_in = '{kind: KIND_ACK, position: exp_ff, out_size: '0,
                          out_tag: '0, last: 1'b1};
            end
            state_in = ST_OUT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         exp_ff       <= '0;
         scan_run_ff  <= 1'b0;
         scan_addr_ff <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         exp_ff       <= exp_in;
         scan_run_ff  <= scan_run_in;
         scan_addr_ff <= scan_addr_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      res_ff        <= res_in;
      drained_ff    <= drained_in;
      cmp_idx_ff    <= cmp_idx_in;
      dup_ff        <= dup_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      hit_found_ff  <= hit_found_in;
      hit_size_ff   <= hit_size_in;
      hit_tag_ff    <= hit_tag_in;
      hit_idx_ff    <= hit_idx_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/srr_cmp_unit.sv =====
// Shared sequence number comparator used by every pass of the sequencer.
module srr_cmp_unit
   import srr_pkg::*;
(
   input  logic [SEQ_W-1:0] a,
   input  logic [SEQ_W-1:0] b,
   output logic             eq,
   output logic             lt
);

   assign eq = (a == b);
   assign lt = (a < b);

endmodule

// ===== rtl/srr_slot_store.sv =====
// Reorder store: slot memory with registered read and per-slot valid flags.
module srr_slot_store
   import srr_pkg::*;
#(
   parameter int REORDER_DEPTH = DEF_REORDER_DEPTH,
   localparam int IDX_W = $clog2(REORDER_DEPTH)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  slot_ctl_type             ctl,
   input  logic [IDX_W-1:0]         idx,
   input  slot_type                 wr_data,
   input  logic [IDX_W-1:0]         rd_addr,
   output slot_type                 rd_data,
   output logic [REORDER_DEPTH-1:0] slot_valid
);

   slot_type                 mem [REORDER_DEPTH];
   slot_type                 rd_data_ff;
   logic [REORDER_DEPTH-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.set_one) begin
         mem[idx] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (ctl.clr_all) begin
         valid_ff <= '0;
      end else if (ctl.clr_one) begin
         valid_ff[idx] <= 1'b0;
      end else if (ctl.set_one) begin
         valid_ff[idx] <= 1'b1;
      end
   end

   assign rd_data    = rd_data_ff;
   assign slot_valid = valid_ff;

endmodule
